// File: rtl/core/fdps_pkg.sv
// Shared constants, configuration codes and stage types for the
// filtered distance servo controller. No dependencies.
`default_nettype none

package fdps_pkg;

	localparam int WINDOW_LEN = 30;
	localparam int PTR_W      = $clog2(WINDOW_LEN);

	localparam int DIST_W     = 13;
	localparam int GAIN_W     = 12;
	localparam int DEG_W      = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 13;

	// running sum of the window and the reciprocal used for sum / WINDOW_LEN
	localparam int SUM_W     = DIST_W + PTR_W;
	localparam int DIV_SHIFT = SUM_W + PTR_W;
	localparam logic [SUM_W:0] DIV_MULT = (SUM_W + 1)'(
		((64'd1 << DIV_SHIFT) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));

	// term is (filtered - setpoint) * gain in 1/4096 degree
	localparam int TERM_W       = (DIST_W + 1) + (GAIN_W + 1);
	localparam int TERM_SHIFT   = 12;
	localparam int ANG_W        = TERM_W + 1;
	localparam int ANGLE_CENTER = 90;
	localparam int ANGLE_TOP    = 180;

	localparam logic [CFG_IDX_W-1:0] CFG_SETPOINT     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_LIMIT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN         = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TERM_MAX     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_TERM_REPL    = 3'd4;

	localparam logic [DIST_W-1:0] RST_SETPOINT     = 13'd272;
	localparam logic [DIST_W-1:0] RST_ACCEPT_LIMIT = 13'd672;
	localparam logic [GAIN_W-1:0] RST_GAIN         = 12'd256;
	localparam logic [DEG_W-1:0]  RST_TERM_MAX     = 8'd180;
	localparam logic [DEG_W-1:0]  RST_TERM_REPL    = 8'd0;

	typedef struct packed {
		logic [DIST_W-1:0] setpoint;
		logic [DIST_W-1:0] accept_limit;
		logic [GAIN_W-1:0] gain;
		logic [DEG_W-1:0]  term_max;
		logic [DEG_W-1:0]  term_repl;
	} cfg_t;

	typedef struct packed {
		logic              enable;
		logic [DIST_W-1:0] filtered;
	} filt_t;

endpackage

`default_nettype wire

// File: rtl/core/fdps_if.sv
// Valid/ready channel interfaces: request, result and configuration write.
// Depends on fdps_pkg.
`default_nettype none

interface fdps_req_if;
	logic                      valid;
	logic                      ready;
	logic                      enable;
	logic [fdps_pkg::DIST_W-1:0] reading;
	modport source (output valid, enable, reading, input ready);
	modport sink (input valid, enable, reading, output ready);
endinterface

interface fdps_rsp_if;
	logic                       valid;
	logic                       ready;
	logic                       drive_valid;
	logic [fdps_pkg::DEG_W-1:0]  drive_angle;
	logic [fdps_pkg::DIST_W-1:0] shown_distance;
	modport source (output valid, drive_valid, drive_angle, shown_distance, input ready);
	modport sink (input valid, drive_valid, drive_angle, shown_distance, output ready);
endinterface

interface fdps_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [fdps_pkg::CFG_IDX_W-1:0]  index;
	logic [fdps_pkg::CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/filtered_distance_p_servo_controller.sv
// Top level of the filtered distance proportional servo controller.
// Depends on fdps_pkg, fdps_if, fdps_filter and fdps_servo.
`default_nettype none

// One request carries an enable level and a distance reading in 1/16 cm and
// yields exactly one result. The block takes a request every cycle as long as
// the result side keeps up; a result passes through five register steps, the
// first at the edge that takes its request (ring RAM read, ring write-back
// with running-sum update, divide by the window length, gain multiply, angle
// saturation into the result register).
// When the result register is full and not taken, the whole pipeline holds and
// req.ready drops. The 30-entry window lives in a synchronous RAM; entries not
// yet written read as zero through per-entry valid bits, so no clearing pass
// follows reset. Configuration writes (cfg, indexes 0 setpoint, 1 accept_limit,
// 2 gain, 3 term_max, 4 term_replacement; others ignored) are always taken and
// should only be issued while no request is in flight.

module filtered_distance_p_servo_controller (
	input  wire logic    clk,
	input  wire logic    arst_n,
	fdps_cfg_if.sink     cfg,
	fdps_req_if.sink     req,
	fdps_rsp_if.source   rsp
);

	fdps_pkg::cfg_t  cfg_q;
	fdps_pkg::filt_t data_s3;
	logic            valid_s3;
	logic            advance;

	// configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.setpoint     <= fdps_pkg::RST_SETPOINT;
			cfg_q.accept_limit <= fdps_pkg::RST_ACCEPT_LIMIT;
			cfg_q.gain         <= fdps_pkg::RST_GAIN;
			cfg_q.term_max     <= fdps_pkg::RST_TERM_MAX;
			cfg_q.term_repl    <= fdps_pkg::RST_TERM_REPL;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				fdps_pkg::CFG_SETPOINT:     cfg_q.setpoint     <= cfg.data;
				fdps_pkg::CFG_ACCEPT_LIMIT: cfg_q.accept_limit <= cfg.data;
				fdps_pkg::CFG_GAIN:         cfg_q.gain <= cfg.data[fdps_pkg::GAIN_W-1:0];
				fdps_pkg::CFG_TERM_MAX:     cfg_q.term_max <= cfg.data[fdps_pkg::DEG_W-1:0];
				fdps_pkg::CFG_TERM_REPL:    cfg_q.term_repl <= cfg.data[fdps_pkg::DEG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// pipeline advances whenever the result register can take a new item
	assign req.ready = advance;

	fdps_filter u_filter (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.req_valid    (req.valid),
		.enable       (req.enable),
		.reading      (req.reading),
		.accept_limit (cfg_q.accept_limit),
		.valid_s3     (valid_s3),
		.data_s3      (data_s3)
	);

	fdps_servo u_servo (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.valid_s3       (valid_s3),
		.data_s3        (data_s3),
		.rsp_ready      (rsp.ready),
		.advance        (advance),
		.rsp_valid      (rsp.valid),
		.drive_valid    (rsp.drive_valid),
		.drive_angle    (rsp.drive_angle),
		.shown_distance (rsp.shown_distance)
	);

endmodule

`default_nettype wire

// File: rtl/core/fdps_filter.sv
// Held distance, moving-average ring in a synchronous RAM, running sum and
// divide by the window length. Depends on fdps_pkg.
`default_nettype none

module fdps_filter (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         advance,
	input  wire logic                         req_valid,
	input  wire logic                         enable,
	input  wire logic [fdps_pkg::DIST_W-1:0]  reading,
	input  wire logic [fdps_pkg::DIST_W-1:0]  accept_limit,
	output logic                              valid_s3,
	output fdps_pkg::filt_t                   data_s3
);

	logic [fdps_pkg::DIST_W-1:0] mem [fdps_pkg::WINDOW_LEN];
	logic [fdps_pkg::DIST_W-1:0] rdata_q;
	logic [fdps_pkg::WINDOW_LEN-1:0] wvld_q;

	logic [fdps_pkg::PTR_W-1:0]  ptr_q;
	logic [fdps_pkg::DIST_W-1:0] held_q;
	logic [fdps_pkg::SUM_W-1:0]  sum_q;
	logic [fdps_pkg::DIST_W-1:0] filtered_q;

	logic                        accept;
	logic [fdps_pkg::DIST_W-1:0] held_next;
	logic                        push;
	logic                        ram_re;
	logic                        ram_we;

	logic                        valid_s1, enable_s1, push_s1;
	logic [fdps_pkg::DIST_W-1:0] sample_s1;
	logic [fdps_pkg::PTR_W-1:0]  addr_s1;
	logic [fdps_pkg::DIST_W-1:0] old_s1;
	logic [fdps_pkg::SUM_W-1:0]  sum_new;

	logic                        valid_s2, enable_s2, push_s2;
	logic [fdps_pkg::SUM_W-1:0]  sum_s2;
	logic [2*fdps_pkg::SUM_W:0]  quot_prod;
	logic [fdps_pkg::DIST_W-1:0] quot;

	// accept side: held distance and window entry decision
	assign accept    = req_valid && advance;
	assign held_next = (reading <= accept_limit) ? reading : held_q;
	assign push      = enable && (held_next < accept_limit);
	assign ram_re    = accept && push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			ptr_q  <= '0;
		end else if (accept && enable) begin
			held_q <= held_next;
			if (push) begin
				ptr_q <= (ptr_q == fdps_pkg::PTR_W'(fdps_pkg::WINDOW_LEN - 1)) ?
					'0 : ptr_q + 1'b1;
			end
		end
	end

	// ring RAM, registered read
	always_ff @(posedge clk) begin
		if (ram_re) begin
			rdata_q <= mem[ptr_q];
		end
		if (ram_we) begin
			mem[addr_s1] <= sample_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			enable_s1 <= enable;
			push_s1   <= push;
			sample_s1 <= held_next;
			addr_s1   <= ptr_q;
		end
	end

	// stage 1: read-modify-write of the ring and the running sum
	assign ram_we  = advance && valid_s1 && push_s1;
	assign old_s1  = wvld_q[addr_s1] ? rdata_q : '0;
	assign sum_new = sum_q - fdps_pkg::SUM_W'(old_s1) + fdps_pkg::SUM_W'(sample_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wvld_q <= '0;
			sum_q  <= '0;
		end else if (ram_we) begin
			wvld_q[addr_s1] <= 1'b1;
			sum_q           <= sum_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			enable_s2 <= enable_s1;
			push_s2   <= push_s1;
			sum_s2    <= sum_new;
		end
	end

	// stage 2: sum / WINDOW_LEN by reciprocal multiply
	assign quot_prod = (2*fdps_pkg::SUM_W + 1)'(sum_s2) * (2*fdps_pkg::SUM_W + 1)'(fdps_pkg::DIV_MULT);
	assign quot      = fdps_pkg::DIST_W'(quot_prod >> fdps_pkg::DIV_SHIFT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filtered_q <= '0;
		end else if (advance && valid_s2 && push_s2) begin
			filtered_q <= quot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (advance) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			data_s3.enable   <= enable_s2;
			data_s3.filtered <= push_s2 ? quot : filtered_q;
		end
	end

	// ring pointer never leaves the window
	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		ptr_q < fdps_pkg::PTR_W'(fdps_pkg::WINDOW_LEN - 1) ||
		ptr_q == fdps_pkg::PTR_W'(fdps_pkg::WINDOW_LEN - 1))
		else $error("window pointer out of range");

	// a write-back never hits the entry being read in the same cycle
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && ram_re) |-> (addr_s1 != ptr_q))
		else $error("ring read and write-back collide");

	// every ring read is followed by its write-back in stage 1
	a_wb_follows_read: assert property (@(posedge clk) disable iff (!arst_n)
		ram_re |=> (valid_s1 && push_s1 && enable_s1))
		else $error("ring read not followed by its write-back stage");

endmodule

`default_nettype wire

// File: rtl/core/fdps_servo.sv
// Proportional term, term replacement, angle saturation and the result
// register with backpressure. Depends on fdps_pkg.
`default_nettype none

module fdps_servo (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire fdps_pkg::cfg_t              cfg,
	input  wire logic                        valid_s3,
	input  wire fdps_pkg::filt_t             data_s3,
	input  wire logic                        rsp_ready,
	output logic                             advance,
	output logic                             rsp_valid,
	output logic                             drive_valid,
	output logic [fdps_pkg::DEG_W-1:0]       drive_angle,
	output logic [fdps_pkg::DIST_W-1:0]      shown_distance
);

	localparam int PAD_W = fdps_pkg::TERM_W - fdps_pkg::DEG_W - fdps_pkg::TERM_SHIFT;
	localparam int WHOLE_W = fdps_pkg::ANG_W - fdps_pkg::TERM_SHIFT;
	localparam logic signed [fdps_pkg::ANG_W-1:0] CENTER_FX =
		fdps_pkg::ANG_W'(fdps_pkg::ANGLE_CENTER * (2 ** fdps_pkg::TERM_SHIFT));
	localparam logic [WHOLE_W-1:0] TOP_W = WHOLE_W'(fdps_pkg::ANGLE_TOP);

	logic signed [fdps_pkg::DIST_W:0]   diff;
	logic signed [fdps_pkg::TERM_W-1:0] term;

	logic                               valid_s4, enable_s4;
	logic [fdps_pkg::DIST_W-1:0]        filt_s4;
	logic signed [fdps_pkg::TERM_W-1:0] term_s4;

	logic signed [fdps_pkg::TERM_W-1:0] term_lim;
	logic signed [fdps_pkg::TERM_W-1:0] term_sub;
	logic signed [fdps_pkg::TERM_W-1:0] term_eff;
	logic signed [fdps_pkg::ANG_W-1:0]  ang_fx;
	logic [WHOLE_W-1:0]                 ang_whole;
	logic [fdps_pkg::DEG_W-1:0]         angle;
	logic                               nonzero;

	assign advance = !rsp_valid || rsp_ready;

	// stage 3: signed error times gain
	assign diff = $signed({1'b0, data_s3.filtered}) - $signed({1'b0, cfg.setpoint});
	assign term = fdps_pkg::TERM_W'(diff) * fdps_pkg::TERM_W'($signed({1'b0, cfg.gain}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (advance) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			enable_s4 <= data_s3.enable;
			filt_s4   <= data_s3.filtered;
			term_s4   <= term;
		end
	end

	// stage 4: replacement, center offset, saturation
	assign term_lim = $signed({{PAD_W{1'b0}}, cfg.term_max, {fdps_pkg::TERM_SHIFT{1'b0}}});
	assign term_sub = $signed({{PAD_W{1'b0}}, cfg.term_repl, {fdps_pkg::TERM_SHIFT{1'b0}}});
	assign term_eff = (term_s4 >= term_lim) ? term_sub : term_s4;
	assign nonzero  = (term_eff != '0);
	assign ang_fx   = CENTER_FX - $signed({term_eff[fdps_pkg::TERM_W-1], term_eff});
	assign ang_whole = ang_fx[fdps_pkg::ANG_W-1:fdps_pkg::TERM_SHIFT];

	always_comb begin
		if (ang_fx <= 0) begin
			angle = '0;
		end else if (ang_whole > TOP_W) begin
			angle = fdps_pkg::DEG_W'(fdps_pkg::ANGLE_TOP);
		end else begin
			angle = ang_whole[fdps_pkg::DEG_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (advance) begin
			rsp_valid <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			drive_valid    <= enable_s4 && nonzero;
			drive_angle    <= (enable_s4 && nonzero) ? angle : '0;
			shown_distance <= enable_s4 ? filt_s4 : '0;
		end
	end

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (drive_angle <= fdps_pkg::DEG_W'(fdps_pkg::ANGLE_TOP)))
		else $error("drive angle above top");

	a_idle_angle: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !drive_valid) |-> (drive_angle == '0))
		else $error("angle set without a command");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s4 && rsp_valid && !rsp_ready) |=> valid_s4)
		else $error("pipeline item lost during stall");

endmodule

`default_nettype wire

// File: tb/sv/fdps_servo_checker.sv
// Scoreboard for the filtered distance servo controller: mirrors the block's
// state and configuration, predicts every request's result and checks rsp.
// Depends on fdps_pkg and fdps_if.
`default_nettype none

module fdps_servo_checker
	import fdps_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	fdps_cfg_if       cfg,
	fdps_req_if       req,
	fdps_rsp_if       rsp,
	output int        fail_count,
	output int        pending
);

	typedef struct packed {
		logic              drive_valid;
		logic [DEG_W-1:0]  drive_angle;
		logic [DIST_W-1:0] shown_distance;
	} servo_cmd_t;

	// mirrored configuration
	logic [DIST_W-1:0] setpoint_q;
	logic [DIST_W-1:0] accept_limit_q;
	logic [GAIN_W-1:0] gain_q;
	logic [DEG_W-1:0]  term_max_q;
	logic [DEG_W-1:0]  term_repl_q;

	// mirrored averaging ring
	logic [DIST_W-1:0] ring [WINDOW_LEN];
	logic [PTR_W-1:0]  ring_ptr;
	logic [SUM_W-1:0]  ring_sum;
	logic [DIST_W-1:0] held_dist;
	logic [DIST_W-1:0] filt_dist;

	servo_cmd_t expected_cmds [$];
	servo_cmd_t want;

	function automatic servo_cmd_t predict_servo_cmd(input logic en,
		input logic [DIST_W-1:0] rd);
		servo_cmd_t cmd;
		int         term;
		int         angle_q12;
		cmd = '0;
		if (!en)
			return cmd;
		if (rd <= accept_limit_q)
			held_dist = rd;
		if (held_dist < accept_limit_q) begin
			ring_sum       = ring_sum - ring[ring_ptr] + SUM_W'(held_dist);
			ring[ring_ptr] = held_dist;
			ring_ptr       = (ring_ptr == PTR_W'(WINDOW_LEN - 1)) ? '0 : ring_ptr + 1'b1;
			filt_dist      = DIST_W'(ring_sum / WINDOW_LEN);
		end
		// term in 1/4096 degree
		term = (int'(filt_dist) - int'(setpoint_q)) * int'(gain_q);
		if (term >= (int'(term_max_q) << TERM_SHIFT))
			term = int'(term_repl_q) << TERM_SHIFT;
		cmd.shown_distance = filt_dist;
		if (term != 0) begin
			cmd.drive_valid = 1'b1;
			angle_q12 = (ANGLE_CENTER << TERM_SHIFT) - term;
			if (angle_q12 > 0) begin
				angle_q12 = angle_q12 >>> TERM_SHIFT;
				cmd.drive_angle = DEG_W'((angle_q12 > ANGLE_TOP) ? ANGLE_TOP : angle_q12);
			end
		end
		return cmd;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setpoint_q     = RST_SETPOINT;
			accept_limit_q = RST_ACCEPT_LIMIT;
			gain_q         = RST_GAIN;
			term_max_q     = RST_TERM_MAX;
			term_repl_q    = RST_TERM_REPL;
			for (int i = 0; i < WINDOW_LEN; i++)
				ring[i] = '0;
			ring_ptr   = '0;
			ring_sum   = '0;
			held_dist  = '0;
			filt_dist  = '0;
			expected_cmds.delete();
			fail_count = 0;
			pending    = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
				CFG_SETPOINT:     setpoint_q     = cfg.data;
				CFG_ACCEPT_LIMIT: accept_limit_q = cfg.data;
				CFG_GAIN:         gain_q         = cfg.data[GAIN_W-1:0];
				CFG_TERM_MAX:     term_max_q     = cfg.data[DEG_W-1:0];
				CFG_TERM_REPL:    term_repl_q    = cfg.data[DEG_W-1:0];
				default: ;
				endcase
			end
			// a result never belongs to a request taken at the same edge
			if (rsp.valid && rsp.ready) begin
				if (expected_cmds.size() == 0) begin
					$error("unexpected result: drive_valid %0d drive_angle %0d shown_distance %0d",
						rsp.drive_valid, rsp.drive_angle, rsp.shown_distance);
					fail_count++;
				end else begin
					want = expected_cmds.pop_front();
					if (rsp.drive_valid !== want.drive_valid) begin
						$error("drive_valid: expected %0d, got %0d", want.drive_valid,
							rsp.drive_valid);
						fail_count++;
					end
					if (rsp.drive_angle !== want.drive_angle) begin
						$error("drive_angle: expected %0d, got %0d", want.drive_angle,
							rsp.drive_angle);
						fail_count++;
					end
					if (rsp.shown_distance !== want.shown_distance) begin
						$error("shown_distance: expected %0d, got %0d", want.shown_distance,
							rsp.shown_distance);
						fail_count++;
					end
				end
			end
			if (req.valid && req.ready)
				expected_cmds.push_back(predict_servo_cmd(req.enable, req.reading));
			pending = expected_cmds.size();
		end
	end

endmodule

`default_nettype wire

// File: tb/sv/filtered_distance_p_servo_controller_tb.sv
// Test top for the filtered distance servo controller: clock, reset, request
// and configuration stimulus, receiver stalls, watchdog and verdict.
// Depends on fdps_pkg, fdps_if, fdps_servo_checker and the block itself.
`default_nettype none

module filtered_distance_p_servo_controller_tb;
	import fdps_pkg::*;

	localparam int IDLE_LIMIT   = 1000;  // cycles with no handshake on any channel
	localparam int RAND_PHASES  = 8;
	localparam int PHASE_ITEMS  = 80;
	localparam int TAIL_CYCLES  = 12;
	localparam int RESET_CYCLES = 11;

	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = CFG_TERM_REPL + 1'b1;
	localparam logic [CFG_IDX_W-1:0] CFG_LAST_UNUSED  = '1;
	localparam logic [DIST_W-1:0]    DIST_MAX         = '1;
	localparam logic [GAIN_W-1:0]    GAIN_MAX         = '1;
	localparam logic [DEG_W-1:0]     DEG_MAX          = '1;

	logic clk = 1'b0;
	logic arst_n;

	int fail_count;
	int pending;
	int send_idle_pct;
	int recv_idle_pct;
	int idle_cycles;

	// current settings, used to aim readings at the interesting spots
	logic [DIST_W-1:0] cur_setpoint;
	logic [DIST_W-1:0] cur_limit;

	fdps_cfg_if cfg ();
	fdps_req_if req ();
	fdps_rsp_if rsp ();

	filtered_distance_p_servo_controller u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.req    (req),
		.rsp    (rsp)
	);

	fdps_servo_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.req        (req),
		.rsp        (rsp),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// receiver back-pressure, redrawn every cycle
	always @(negedge clk) begin
		rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// One configuration write. Entered and left at a falling edge; valid drops
	// between one write and the next.
	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= value;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		@(negedge clk);
		cfg.valid <= 1'b0;
		@(negedge clk);
	endtask

	// Full register set plus a write to an index the block must ignore.
	task automatic apply_settings(input logic [DIST_W-1:0] sp, input logic [DIST_W-1:0] lim,
		input logic [GAIN_W-1:0] g, input logic [DEG_W-1:0] tmax,
		input logic [DEG_W-1:0] trepl);
		write_register(CFG_IDX_W'($urandom_range(CFG_LAST_UNUSED, CFG_FIRST_UNUSED)),
			CFG_DATA_W'($urandom));
		write_register(CFG_SETPOINT, CFG_DATA_W'(sp));
		write_register(CFG_ACCEPT_LIMIT, CFG_DATA_W'(lim));
		write_register(CFG_GAIN, CFG_DATA_W'(g));
		write_register(CFG_TERM_MAX, CFG_DATA_W'(tmax));
		write_register(CFG_TERM_REPL, CFG_DATA_W'(trepl));
		cur_setpoint = sp;
		cur_limit    = lim;
	endtask

	// One request. Entered and left at a falling edge. Valid stays high on
	// exit so back-to-back requests follow without a gap; it only drops when a
	// gap is drawn here or when the caller drains.
	task automatic send_request(input logic en, input logic [DIST_W-1:0] rd);
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid   <= 1'b0;
			req.enable  <= 1'($urandom);
			req.reading <= DIST_W'($urandom);
			@(negedge clk);
		end
		req.valid   <= 1'b1;
		req.enable  <= en;
		req.reading <= rd;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Stop requesting and wait until every result has been taken. Each request
	// yields a result, so an empty scoreboard means the block is idle.
	task automatic drain();
		req.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	// Readings clustered at the setpoint (zero term after the average
	// settles), around the accept limit, and spread over the whole field.
	function automatic logic [DIST_W-1:0] pick_reading();
		int          v;
		int unsigned sel;
		sel = $urandom_range(99);
		if (sel < 30)
			v = int'(cur_setpoint) + int'($urandom_range(6)) - 3;
		else if (sel < 55)
			v = int'($urandom_range(cur_limit));
		else if (sel < 70)
			v = int'(cur_limit) + int'($urandom_range(4)) - 2;
		else if (sel < 80)
			v = int'($urandom_range(DIST_MAX, cur_limit));
		else
			v = int'($urandom_range(DIST_MAX));
		if (v < 0)
			v = 0;
		if (v > int'(DIST_MAX))
			v = int'(DIST_MAX);
		return DIST_W'(v);
	endfunction

	// Watchdog: ends the run when no channel moves for too long.
	initial begin
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready) ||
				(cfg.valid && cfg.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("filtered_distance_p_servo_controller test failed");
		$finish;
	end

	initial begin
		arst_n      = 1'b0;
		cfg.valid   = 1'b0;
		cfg.index   = '0;
		cfg.data    = '0;
		req.valid   = 1'b0;
		req.enable  = 1'b0;
		req.reading = '0;
		rsp.ready   = 1'b0;
		send_idle_pct = 18;
		recv_idle_pct = 84;
		cur_setpoint  = RST_SETPOINT;
		cur_limit     = RST_ACCEPT_LIMIT;

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// ---- directed part, reset settings ----
		// disabled requests report nothing and leave the state alone, then a zero reading
		send_request(1'b0, DIST_MAX);
		send_request(1'b0, '0);
		send_request(1'b1, '0);
		// above the limit: previous held distance is reused and averaged
		send_request(1'b1, DIST_MAX);
		// exactly at the limit: held, but kept out of the window
		send_request(1'b1, RST_ACCEPT_LIMIT);
		send_request(1'b1, RST_ACCEPT_LIMIT + 1'b1);
		repeat (6) send_request(1'b1, RST_ACCEPT_LIMIT - 1'b1);
		drain();

		// huge positive term: at or above term_max, so replaced
		apply_settings('0, DIST_MAX, GAIN_MAX, 8'd20, 8'd5);
		send_request(1'b1, DIST_MAX);
		repeat (3) send_request(1'b1, DIST_MAX - 1'b1);
		drain();

		// term past the center but under term_max: angle floors at zero
		apply_settings('0, DIST_MAX, 12'd400, DEG_MAX, '0);
		send_request(1'b1, DIST_MAX - 1'b1);
		drain();

		// huge negative term: angle saturates at the top
		apply_settings(DIST_MAX, DIST_MAX, GAIN_MAX, DEG_MAX, '0);
		repeat (2) send_request(1'b1, '0);
		drain();

		// zero gain: zero term, no new angle commanded
		apply_settings(RST_SETPOINT, RST_ACCEPT_LIMIT, '0, '0, '0);
		repeat (2) send_request(1'b1, 13'd100);
		drain();

		// ---- random part ----
		// Phases 0..2: slow receiver; 3..5: slow sender; 6..7: full rate.
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			if (ph < 3) begin
				send_idle_pct = 18;
				recv_idle_pct = 84;
			end else if (ph < 6) begin
				send_idle_pct = 84;
				recv_idle_pct = 18;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			case (ph)
			0: apply_settings(RST_SETPOINT, RST_ACCEPT_LIMIT, RST_GAIN, RST_TERM_MAX,
				RST_TERM_REPL);
			1: apply_settings(DIST_MAX, DIST_MAX, GAIN_MAX, DEG_MAX, DEG_MAX);
			2: apply_settings('0, '0, '0, '0, '0);
			default: apply_settings(DIST_W'($urandom_range(1500)),
				DIST_W'($urandom_range(DIST_MAX, 200)), GAIN_W'($urandom_range(GAIN_MAX)),
				DEG_W'($urandom_range(DEG_MAX)), DEG_W'($urandom_range(DEG_MAX)));
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_request($urandom_range(99) < 92, pick_reading());
			drain();
		end

		// let any stray result show up before the verdict
		repeat (TAIL_CYCLES) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("filtered_distance_p_servo_controller test passed");
		else
			$display("filtered_distance_p_servo_controller test failed");
		$finish;
	end

endmodule

`default_nettype wire

// File: filelist.f
rtl/core/fdps_pkg.sv
rtl/core/fdps_if.sv
rtl/core/fdps_filter.sv
rtl/core/fdps_servo.sv
rtl/core/filtered_distance_p_servo_controller.sv
tb/sv/fdps_servo_checker.sv
tb/sv/filtered_distance_p_servo_controller_tb.sv
